/* design/homogeneous_vertex_transform_top_assert.svh */
// Assertion macros for the vertex transform block.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_TOP_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HVT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hvt assertion failed");
`define HVT_ASSERT_HOLD(name, cond, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error("hvt hold assertion failed");
`else
`define HVT_ASSERT(name, prop)
`define HVT_ASSERT_HOLD(name, cond, sig)
`endif
`endif

/* design/hvt_pkg.sv */
package hvt_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_REGS        = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int CELL_W          = 32;
  localparam int FIELD_W         = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_RIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_LEFT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_RIGHT = 3'd7;
endpackage

/* design/homogeneous_vertex_transform_top.sv */
// Vertex transform: each item (x, y, z) is taken as (x, y, z, 1), multiplied by the 4x4
// row-major matrix in the eight configuration registers (identity after reset), and the
// first three results are divided by the fourth, truncated toward zero, saturated to the
// coordinate range. One item per cycle while the output register is not stalled; the
// restoring divider resolves one quotient bit per pipeline stage. A zero fourth result
// gives zero coordinates with w_zero set. The whole pipeline advances whenever the
// output register is empty or being taken.
`include "homogeneous_vertex_transform_top_assert.svh"
module homogeneous_vertex_transform_top #(
  parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hvt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [3*hvt_pkg::FIELD_W-1:0]    s_axis_tdata,  // in_x, in_y, in_z
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [3*hvt_pkg::FIELD_W-1:0]    m_axis_tdata,  // out_x, out_y, out_z
  output logic [1:0]                       m_axis_tuser   // w_zero, overflowed
);
  import hvt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int PW = CELL_W + CW;
  localparam int TW = CELL_W + FB;
  localparam int SW = ((PW > TW) ? PW : TW) + 2;
  localparam int NW = SW + FB;

  logic ce;
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // configuration
  logic [CFG_DATA_W-1:0] cfg_q [NUM_REGS];
  logic signed [CELL_W-1:0] cells [16];
  logic [CFG_DATA_W-1:0] one_lo, one_hi;
  assign one_lo = CFG_DATA_W'(64'd1) << FB;
  assign one_hi = one_lo << 32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) cfg_q[k] <= '0;
      cfg_q[REG_ROW0_LEFT]  <= one_lo;
      cfg_q[REG_ROW1_LEFT]  <= one_hi;
      cfg_q[REG_ROW2_RIGHT] <= one_lo;
      cfg_q[REG_ROW3_RIGHT] <= one_hi;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) cells[k] = cfg_q[k/2][(k%2)*CELL_W +: CELL_W];
  end

  // stage 1: products
  logic signed [CW-1:0] coord [3];
  logic signed [PW-1:0] prod_q [4][3];
  logic vld1_q;
  always_comb begin
    for (int j = 0; j < 3; j++) coord[j] = s_axis_tdata[FIELD_W*j +: CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (ce) vld1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++)
          prod_q[i][j] <= PW'(cells[4*i+j]) * PW'(coord[j]);
    end
  end

  // stage 2: row sums, w column is the cell scaled by 1.0
  logic signed [SW-1:0] sum_q [4];
  logic vld2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld2_q <= 1'b0;
    else if (ce) vld2_q <= vld1_q;
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 4; i++)
        sum_q[i] <= SW'(prod_q[i][0]) + SW'(prod_q[i][1]) + SW'(prod_q[i][2])
                  + (SW'(cells[4*i+3]) <<< FB);
    end
  end

  // divider pipeline, index 0 is the setup stage
  logic [SW-1:0] den_q [CW+1];
  logic [SW-1:0] rem_q [CW+1][3];
  logic [CW-1:0] num_q [CW+1][3];
  logic [CW-1:0] quo_q [CW+1][3];
  logic          big_q [CW+1][3];
  logic          neg_q [CW+1][3];
  logic          wz_q  [CW+1];
  logic          vld_q [CW+1];

  logic [SW-1:0] dmag;
  logic [SW-1:0] nmag [3];
  logic [NW-1:0] nfull [3];
  logic [NW-1:0] nhi [3];
  always_comb begin
    dmag = sum_q[3][SW-1] ? SW'(-sum_q[3]) : SW'(sum_q[3]);
    for (int c = 0; c < 3; c++) begin
      nmag[c]  = sum_q[c][SW-1] ? SW'(-sum_q[c]) : SW'(sum_q[c]);
      nfull[c] = NW'(nmag[c]) << FB;
      nhi[c]   = nfull[c] >> CW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (ce) vld_q[0] <= vld2_q;
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      den_q[0] <= dmag;
      wz_q[0]  <= (dmag == '0);
      for (int c = 0; c < 3; c++) begin
        // quotient of 2^CW or more saturates in any case
        big_q[0][c] <= (nhi[c] >= NW'(dmag));
        rem_q[0][c] <= SW'(nhi[c]);
        num_q[0][c] <= nfull[c][CW-1:0];
        quo_q[0][c] <= '0;
        neg_q[0][c] <= sum_q[c][SW-1] ^ sum_q[3][SW-1];
      end
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [SW:0] part [3];
    logic        ge [3];
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        part[c] = {rem_q[k][c], num_q[k][c][CW-1]};
        ge[c]   = part[c] >= {1'b0, den_q[k]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (ce) vld_q[k+1] <= vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (ce) begin
        den_q[k+1] <= den_q[k];
        wz_q[k+1]  <= wz_q[k];
        for (int c = 0; c < 3; c++) begin
          rem_q[k+1][c] <= ge[c] ? SW'(part[c] - {1'b0, den_q[k]}) : SW'(part[c]);
          num_q[k+1][c] <= num_q[k][c] << 1;
          quo_q[k+1][c] <= {quo_q[k][c][CW-2:0], ge[c]};
          big_q[k+1][c] <= big_q[k][c];
          neg_q[k+1][c] <= neg_q[k][c];
        end
      end
    end
  end

  // output stage: sign, saturation
  logic [CW-1:0] lim [3];
  logic [CW-1:0] mag [3];
  logic [CW-1:0] res [3];
  logic          sat [3];
  logic [3*FIELD_W-1:0] tdata_d;
  logic [1:0]    tuser_d;
  logic [3*FIELD_W-1:0] tdata_q;
  logic [1:0]    tuser_q;
  logic          out_vld_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lim[c] = neg_q[CW][c] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      sat[c] = big_q[CW][c] || (quo_q[CW][c] > lim[c]);
      mag[c] = sat[c] ? lim[c] : quo_q[CW][c];
      res[c] = neg_q[CW][c] ? CW'(-mag[c]) : mag[c];
      tdata_d[FIELD_W*c +: FIELD_W] = wz_q[CW] ? '0 : FIELD_W'($signed(res[c]));
    end
    tuser_d[0] = wz_q[CW];
    tuser_d[1] = !wz_q[CW] && (sat[0] || sat[1] || sat[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (ce) out_vld_q <= vld_q[CW];
  end
  always_ff @(posedge clk_i) begin
    if (ce) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  `HVT_ASSERT(a_ready_follows_output, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `HVT_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> vld1_q)
  `HVT_ASSERT(a_wzero_clean, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
  `HVT_ASSERT_HOLD(a_stall_holds_last, (!ce && vld_q[CW]), quo_q[CW][0])

endmodule

/* sim/tb_homogeneous_vertex_transform_top.sv */
module tb_homogeneous_vertex_transform_top;
  import hvt_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = CW + 4;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
    logic        ovf;
  } proj_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [3*FIELD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*FIELD_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  homogeneous_vertex_transform_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0] matrix_regs [NUM_REGS];
  vertex_t     vertex_q [$];
  proj_t       proj_q [$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_wzero = 0;
  int          n_ovf = 0;
  bit          drive_en = 1'b0;
  bit          sink_hold = 1'b0;
  int          src_gap = 0;
  int          sink_gap = 0;

  function automatic logic signed [31:0] cell_of(int idx);
    logic [63:0] r;
    r = matrix_regs[idx >> 1];
    return (idx & 1) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic [31:0] divide_sat(logic signed [127:0] num,
                                             logic signed [127:0] den, ref logic ovf);
    logic neg;
    logic [127:0] n, d, q;
    logic [63:0] lim, mag;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    lim = neg ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
    q = (n << FB) / d;
    if (q > {64'd0, lim}) begin
      ovf = 1'b1;
      mag = lim;
    end else begin
      mag = q[63:0];
    end
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic proj_t transform_vertex(vertex_t v);
    logic signed [127:0] t [4];
    logic signed [127:0] r [4];
    proj_t p;
    logic ovf;
    t[0] = $signed(v.x);
    t[1] = $signed(v.y);
    t[2] = $signed(v.z);
    t[3] = 128'sd1 << FB;
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
      for (int j = 0; j < 4; j++) r[i] += 128'(cell_of(4 * i + j)) * t[j];
    end
    p = '{default: '0};
    if (r[3] == 0) begin
      p.w_zero = 1'b1;
      return p;
    end
    ovf = 1'b0;
    p.x = divide_sat(r[0], r[3], ovf);
    p.y = divide_sat(r[1], r[3], ovf);
    p.z = divide_sat(r[2], r[3], ovf);
    p.ovf = ovf;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %h want %h (item %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // driver: one nonblocking write per signal per edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        proj_q.push_back(transform_vertex(vertex_q.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (drive_en && vertex_q.size() > 0 &&
                   (src_gap == 0 || (s_axis_tvalid && s_axis_tready && src_gap == 0))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= vertex_q[0];
        src_gap = ($urandom_range(0, 9) < 6) ? 0 :
                  ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
      end else begin
        s_axis_tvalid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end
    end
  end

  // monitor and sink
  always @(posedge clk_i) begin
    proj_t want;
    logic [31:0] gx, gy, gz;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        {gz, gy, gx} = m_axis_tdata;
        if (proj_q.size() == 0) begin
          report_mismatch("unexpected item", gx, 32'd0);
        end else begin
          want = proj_q.pop_front();
          if (gx !== want.x) report_mismatch("out_x", gx, want.x);
          if (gy !== want.y) report_mismatch("out_y", gy, want.y);
          if (gz !== want.z) report_mismatch("out_z", gz, want.z);
          if (m_axis_tuser[0] !== want.w_zero)
            report_mismatch("w_zero", 32'(m_axis_tuser[0]), 32'(want.w_zero));
          if (m_axis_tuser[1] !== want.ovf)
            report_mismatch("overflowed", 32'(m_axis_tuser[1]), 32'(want.ovf));
          n_wzero += want.w_zero;
          n_ovf += want.ovf;
        end
        n_checked++;
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 9) >= 7)
          sink_gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    matrix_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // source keeps sending until its queue is empty, then everything drains
  task automatic drain();
    while (vertex_q.size() > 0 || proj_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    drive_en = 1'b0;
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 2000 << 8)) - (1000 << 8)) <<< 8;
    endcase
  endfunction

  function automatic logic [31:0] rand_cell();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
      default: return 32'($signed($urandom_range(0, 64 << FB)) - (32 << FB));
    endcase
  endfunction

  task automatic load_matrix(int kind);
    logic [31:0] c [16];
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: c[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'd0;
        1: c[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        2: c[i] = (i == 14) ? 32'h0001_0000 : rand_cell();  // z weight in w is 1.0: perspective
        3: c[i] = (i >= 12) ? 32'd0 : rand_cell();          // w always zero
        4: c[i] = (i == 15) ? 32'd1 : rand_cell();          // smallest w offset cell
        default: c[i] = rand_cell();
      endcase
    end
    for (int k = 0; k < NUM_REGS; k++) write_reg(k[CFG_IDX_W-1:0], {c[2 * k + 1], c[2 * k]});
  endtask

  task automatic run_random(int n);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord();
      v.y = rand_coord();
      v.z = rand_coord();
      vertex_q.push_back(v);
    end
    drive_en = 1'b1;
  endtask

  initial begin
    logic [31:0] ext [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                             32'h0001_0000, 32'hffff_0000};
    vertex_t v;
    matrix_regs[0] = 64'd65536;
    matrix_regs[1] = 64'd0;
    matrix_regs[2] = 64'd65536 << 32;
    matrix_regs[3] = 64'd0;
    matrix_regs[4] = 64'd0;
    matrix_regs[5] = 64'd65536;
    matrix_regs[6] = 64'd0;
    matrix_regs[7] = 64'd65536 << 32;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes through the reset identity
    for (int i = 0; i < 6; i++) begin
      v.x = ext[i];
      v.y = ext[(i + 1) % 6];
      v.z = ext[(i + 2) % 6];
      vertex_q.push_back(v);
    end
    drive_en = 1'b1;
    drain();
    load_matrix(3);  // zero w
    for (int i = 0; i < 3; i++) vertex_q.push_back({ext[i], ext[i + 1], ext[i + 2]});
    drive_en = 1'b1;
    drain();
    load_matrix(1);  // extreme cells, saturation both ways
    for (int i = 0; i < 6; i++) vertex_q.push_back({ext[i], ext[5 - i], ext[i]});
    drive_en = 1'b1;
    drain();
    load_matrix(4);
    run_random(100);
    drain();
    load_matrix(0);
    // long sink stall while the source keeps offering items
    sink_hold = 1'b1;
    run_random(80);
    repeat (150) @(posedge clk_i);
    sink_hold = 1'b0;
    drain();
    for (int p = 0; p < 10; p++) begin
      load_matrix((p % 3 == 0) ? 2 : (p == 7 ? 3 : 5));
      run_random(60);
      drain();
    end
    $display("checked %0d vertices over 15 matrix settings: %0d zero-w, %0d saturated",
             n_checked, n_wzero, n_ovf);
    if (n_errors == 0) begin
      $display("homogeneous_vertex_transform_top regression: pass");
    end else begin
      $display("homogeneous_vertex_transform_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("homogeneous_vertex_transform_top regression: fail");
    $finish;
  end
endmodule
